FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain condition, checked at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/swji_pkg.sv
// ----------------------------------------------------------------------------
// swji_pkg
// Shared types and constants of the seeded window jet isolation block.
// ----------------------------------------------------------------------------
package swji_pkg;

    localparam int COORD_W    = 5;
    localparam int SCALE_W    = 16;
    localparam int THR_W      = 26;
    localparam int ISO_W      = 10;
    localparam int SUM_OUT_W  = 22;
    localparam int SEED_OUT_W = 26;
    localparam int CFG_DATA_W = 26;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_DATA_W = 56;
    localparam int NBR_W      = 4;

    localparam logic [NBR_W-1:0] NBR_FULL = 4'd8;
    localparam logic [NBR_W-1:0] NBR_EDGE = 4'd5;

    localparam logic [1:0] WIN_LAST = 2'd2;
    localparam logic [1:0] WIN_MID  = 2'd1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ET_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ISO_THR    = 2'd2;

    localparam logic [SCALE_W-1:0] ET_SCALE_RST = 16'd128;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DRAIN
    } state_t;

endpackage

FILE: src/seeded_window_jet_isolation.sv
// ----------------------------------------------------------------------------
// seeded_window_jet_isolation
// Region grid store with a 3x3 seeded window sum, threshold and isolation flag.
// ----------------------------------------------------------------------------
// Write: taken while idle, no result.
// Query: up to nine grid reads through one memory port plus a two-stage multiply and
//   accumulate; no new input is taken until the result is loaded into the output.
// Reset: a clearing pass over all PHI_BINS*ETA_BINS cells (396 by default) zeroes
//   the valid marks; no input is taken until it ends, configuration is.
module seeded_window_jet_isolation
    import swji_pkg::*;
#(
    parameter int PHI_BINS    = 18,
    parameter int ETA_BINS    = 22,
    parameter int ENERGY_BITS = 10,
    localparam int IN_DATA_W  = ((2 * COORD_W + ENERGY_BITS + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // cfg_data: register value, low bits used per register
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // s_axis_tdata: grid_eta, grid_phi, region_energy, zero fill
    input  logic [IN_DATA_W-1:0]       s_axis_tdata,
    // s_axis_tuser: operation
    input  logic                       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // m_axis_tdata: window_sum_gev, seed_energy_scaled, is_isolated,
    //               neighbor_fault, zero fill
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int NCELLS    = PHI_BINS * ETA_BINS;
    localparam int ADDR_W    = $clog2(NCELLS);
    localparam int WORD_W    = ENERGY_BITS + 1;
    localparam int NC_W      = COORD_W + 1;
    localparam int PROD_W    = ENERGY_BITS + SCALE_W;
    localparam int CMP_W     = (PROD_W > THR_W) ? PROD_W : THR_W;
    localparam int SUM_W     = PROD_W + 4;
    localparam int WIDE_W    = (SUM_W > SEED_OUT_W + 9) ? SUM_W : SEED_OUT_W + 9;
    localparam int PAD_W     = OUT_DATA_W - SUM_OUT_W - SEED_OUT_W - 2;

    // grid memory: {valid, energy}
    logic [WORD_W-1:0]  mem [NCELLS];
    logic [WORD_W-1:0]  rd_data_reg;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [1:0]            row_reg, row_next;
    logic [1:0]            col_reg, col_next;
    logic [COORD_W-1:0]    eta_reg, phi_reg;
    logic                  bad_reg;

    logic [SCALE_W-1:0]    et_scale_reg;
    logic [THR_W-1:0]      region_thr_reg;
    logic [ISO_W-1:0]      iso_thr_reg;

    logic                  s1_valid_reg, s1_present_reg, s1_center_reg;
    logic                  s2_valid_reg, s2_cell_reg, s2_center_reg;
    logic [PROD_W-1:0]     s2_prod_reg;

    logic [SUM_W-1:0]      sum_reg;
    logic [PROD_W-1:0]     seed_reg;
    logic [NBR_W-1:0]      count_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_load;

    logic [COORD_W-1:0]    in_eta, in_phi;
    logic [ENERGY_BITS-1:0] in_energy;
    logic                  in_range;
    logic                  in_fire;
    logic                  query_start;

    logic [NC_W-1:0]       ne, np;
    logic                  row_ok;
    logic                  slot_present;
    logic                  pipe_empty;

    logic [CMP_W-1:0]      cell_val;
    logic [WIDE_W-1:0]     sum_wide, seed_wide, gev_wide;
    logic [SUM_OUT_W-1:0]  gev_out;
    logic [SEED_OUT_W-1:0] seed_out;
    logic                  edge_row;
    logic                  fault, iso;

    assign in_eta    = s_axis_tdata[COORD_W-1:0];
    assign in_phi    = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_energy = s_axis_tdata[2*COORD_W+ENERGY_BITS-1:2*COORD_W];
    assign in_range  = (32'(in_eta) < ETA_BINS) && (32'(in_phi) < PHI_BINS);
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign query_start = in_fire && (s_axis_tuser == OP_QUERY);

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign pipe_empty    = !s1_valid_reg && !s2_valid_reg;

    // window slot address
    always_comb
    begin
        case (row_reg)
            2'd0:    ne = NC_W'(eta_reg) - NC_W'(1);
            2'd2:    ne = NC_W'(eta_reg) + NC_W'(1);
            default: ne = NC_W'(eta_reg);
        endcase
        case (col_reg)
            2'd0:    np = (phi_reg == '0) ? NC_W'(PHI_BINS - 1) : NC_W'(phi_reg) - NC_W'(1);
            2'd2:    np = (32'(phi_reg) + 1 == PHI_BINS) ? '0 : NC_W'(phi_reg) + NC_W'(1);
            default: np = NC_W'(phi_reg);
        endcase
        case (row_reg)
            2'd0:    row_ok = (eta_reg != '0);
            2'd2:    row_ok = (32'(eta_reg) + 1 < ETA_BINS);
            default: row_ok = 1'b1;
        endcase
    end

    assign slot_present = !bad_reg && row_ok;
    assign rd_en   = (state_reg == ST_READ) && slot_present;
    assign rd_addr = ADDR_W'(ne) * ADDR_W'(PHI_BINS) + ADDR_W'(np);

    // state machine and memory write port
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        wr_en        = 1'b0;
        wr_addr      = ADDR_W'(in_eta) * ADDR_W'(PHI_BINS) + ADDR_W'(in_phi);
        wr_data      = {1'b1, in_energy};
        out_load     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(NCELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire && s_axis_tuser == OP_WRITE)
                begin
                    wr_en = in_range;
                end
                if (query_start)
                begin
                    row_next   = '0;
                    col_next   = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (col_reg == WIN_LAST)
                begin
                    col_next = '0;
                    row_next = row_reg + 2'd1;
                    if (row_reg == WIN_LAST)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    col_next = col_reg + 2'd1;
                end
            end
            ST_DRAIN:
            begin
                if (pipe_empty && (!out_valid_reg || m_axis_tready))
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            et_scale_reg   <= ET_SCALE_RST;
            region_thr_reg <= '0;
            iso_thr_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ET_SCALE:   et_scale_reg   <= cfg_data[SCALE_W-1:0];
                CFG_REGION_THR: region_thr_reg <= cfg_data[THR_W-1:0];
                CFG_ISO_THR:    iso_thr_reg    <= cfg_data[ISO_W-1:0];
                default:        ;
            endcase
        end
    end

    // query seed capture
    always_ff @(posedge clk)
    begin
        if (query_start)
        begin
            eta_reg <= in_eta;
            phi_reg <= in_phi;
            bad_reg <= !in_range;
        end
    end

    // read, scale, threshold and accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= (state_reg == ST_READ);
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_present_reg <= slot_present;
        s1_center_reg  <= (row_reg == WIN_MID) && (col_reg == WIN_MID);
        s2_prod_reg    <= PROD_W'(rd_data_reg[ENERGY_BITS-1:0]) * PROD_W'(et_scale_reg);
        s2_cell_reg    <= s1_present_reg && rd_data_reg[ENERGY_BITS];
        s2_center_reg  <= s1_center_reg;
    end

    assign cell_val = (s2_cell_reg && (CMP_W'(s2_prod_reg) >= CMP_W'(region_thr_reg)))
                      ? CMP_W'(s2_prod_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (query_start)
        begin
            sum_reg   <= '0;
            seed_reg  <= '0;
            count_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(cell_val);
            if (s2_center_reg)
            begin
                seed_reg <= PROD_W'(cell_val);
            end
            else if (s2_cell_reg)
            begin
                count_reg <= count_reg + NBR_W'(1);
            end
        end
    end

    // result formatting
    assign sum_wide  = WIDE_W'(sum_reg);
    assign seed_wide = WIDE_W'(seed_reg);
    assign gev_wide  = sum_wide >> 8;
    assign gev_out   = (gev_wide > WIDE_W'({SUM_OUT_W{1'b1}}))
                       ? {SUM_OUT_W{1'b1}} : gev_wide[SUM_OUT_W-1:0];
    assign seed_out  = (seed_wide > WIDE_W'({SEED_OUT_W{1'b1}}))
                       ? {SEED_OUT_W{1'b1}} : seed_wide[SEED_OUT_W-1:0];
    assign edge_row  = (eta_reg == '0) || (32'(eta_reg) == ETA_BINS - 1);
    assign fault     = bad_reg || ((count_reg != NBR_FULL)
                       && !(edge_row && count_reg == NBR_EDGE));
    assign iso       = !bad_reg && (iso_thr_reg != '0)
                       && (gev_out < SUM_OUT_W'(iso_thr_reg));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, fault, iso, seed_out, gev_out};
        end
    end

`include "assert_macros.svh"

    `ASSERT_NEXT(a_query_enters_read, query_start, state_reg == ST_READ, "query did not start reads")
    `ASSERT_IMP(a_stage2_follows, s2_valid_reg, $past(s1_valid_reg), "stage 2 without stage 1")
    `ASSERT_IMP(a_count_bound, out_load, count_reg <= NBR_FULL, "neighbor count above eight")
    `ASSERT_IMP(a_load_pipe_empty, out_load, pipe_empty && !rd_en, "result loaded mid window")
    `ASSERT_IMP(a_no_write_in_query, wr_en, state_reg == ST_CLEAR || state_reg == ST_IDLE, "write during query")

endmodule
